>>> design/glob_path_match_defines.svh
// Assertion macros used by the checker module.
`ifndef GLOB_PATH_MATCH_DEFINES_SVH
`define GLOB_PATH_MATCH_DEFINES_SVH

// Checked only while the block is out of reset.
`define GPM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GPM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/gpm_pkg.sv
package gpm_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_BYTE  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        KIND_LITERAL   = 2'd0,
        KIND_SINGLE    = 2'd1,
        KIND_LAYER     = 2'd2,
        KIND_LAYER_ANY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_PATTERN_LENGTH  = 2'd0,
        REG_SEPARATOR_BYTE  = 2'd1,
        REG_SEPARATOR_CHECK = 2'd2
    } t_reg;

    localparam logic [5:0] LEN_RESET       = 6'd0;
    localparam logic [7:0] SEP_BYTE_RESET  = 8'd47;
    localparam logic       SEP_CHECK_RESET = 1'b1;

    typedef struct packed {
        logic       start;
        logic       advance;
        logic       blocked;
        logic [7:0] text_byte;
    } t_cell_ctl;

    typedef struct packed {
        logic       we;
        t_kind      kind;
        logic [7:0] lit_byte;
    } t_cell_load;

    typedef struct packed {
        logic valid;
        logic matched;
    } t_result;

endpackage

>>> design/gpm_cell.sv
module gpm_cell
    import gpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_cell_load i_load,
    input  logic       i_diag,
    input  logic       i_chain,
    output logic       o_bit,
    output logic       o_chain
);

    t_kind      r_kind;
    logic [7:0] r_byte;
    logic       r_bit;
    logic       n_bit;
    logic       w_star;
    logic       w_step;

    assign w_star = (r_kind == KIND_LAYER) || (r_kind == KIND_LAYER_ANY);

    always_comb begin
        unique case (r_kind)
            KIND_LITERAL:   w_step = i_diag && (i_ctl.text_byte == r_byte);
            KIND_SINGLE:    w_step = i_diag && !i_ctl.blocked;
            KIND_LAYER:     w_step = i_chain || (r_bit && !i_ctl.blocked);
            KIND_LAYER_ANY: w_step = i_chain || r_bit;
            default:        w_step = 1'b0;
        endcase
    end

    always_comb begin
        o_chain = i_ctl.start ? (i_chain && w_star) : w_step;
        n_bit   = (i_ctl.start || i_ctl.advance) ? o_chain : r_bit;
    end

    assign o_bit = r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.we) begin
            r_kind <= i_load.kind;
            r_byte <= i_load.lit_byte;
        end
    end

endmodule

>>> design/gpm_out_stage.sv
module gpm_out_stage
    import gpm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output logic    o_matched,
    output logic    o_full
);

    logic r_out_valid;
    logic r_out_matched;
    logic r_skid_valid;
    logic r_skid_matched;
    logic n_out_valid;
    logic n_out_matched;
    logic n_skid_valid;
    logic n_skid_matched;

    always_comb begin
        n_out_valid    = r_out_valid;
        n_out_matched  = r_out_matched;
        n_skid_valid   = r_skid_valid;
        n_skid_matched = r_skid_matched;
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                n_out_valid   = 1'b1;
                n_out_matched = r_skid_matched;
                n_skid_valid  = 1'b0;
            end else begin
                n_out_valid   = i_res.valid;
                n_out_matched = i_res.matched;
            end
        end else if (i_res.valid) begin
            n_skid_valid   = 1'b1;
            n_skid_matched = i_res.matched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_matched  <= n_out_matched;
        r_skid_matched <= n_skid_matched;
    end

    assign o_valid   = r_out_valid;
    assign o_matched = r_out_matched;
    assign o_full    = r_skid_valid;

endmodule

>>> design/glob_path_match.sv
// Channel   | Direction | Handshake          | Payload
// input     | in        | i_valid / o_stall  | i_func i_entry_slot i_entry_kind
//           |           |                    | i_entry_byte i_text_byte
// result    | out       | o_valid / i_stall  | o_matched
// config    | in        | APB psel / penable | paddr pwdata prdata
//
// One item is taken per cycle while o_stall is low; a start or byte result is registered in the output stage.
// The rate rests on the combinational one-bit ripple through the row of pattern cells.
// Synchronous reset clears the match row to bit zero only and restores the registers.
// Pattern entries are not cleared by reset.
// A two-entry output stage lets input continue while one result waits on a stall.
module glob_path_match
    import gpm_pkg::*;
#(
    parameter int PATTERN_MAX = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_entry_slot,
    input  logic [1:0]  i_entry_kind,
    input  logic [7:0]  i_entry_byte,
    input  logic [7:0]  i_text_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_matched,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(PATTERN_MAX + 1);

    logic [5:0]  r_len;
    logic [7:0]  r_sep;
    logic        r_sep_chk;
    logic        r_row0;
    logic        n_row0;
    logic        w_accept;
    logic        w_load;
    logic        w_cfg_we;
    logic        w_full;
    logic [IDX_W-1:0] w_used;
    t_cell_ctl   w_ctl;
    t_result     w_res;
    logic        w_chain [0:PATTERN_MAX];
    logic        w_bit   [0:PATTERN_MAX];

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;
    assign w_accept = i_valid && !o_stall;
    assign o_stall  = w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LEN_RESET;
            r_sep     <= SEP_BYTE_RESET;
            r_sep_chk <= SEP_CHECK_RESET;
        end else if (w_cfg_we) begin
            unique case (t_reg'(paddr[3:2]))
                REG_PATTERN_LENGTH:  r_len     <= pwdata[5:0];
                REG_SEPARATOR_BYTE:  r_sep     <= pwdata[7:0];
                REG_SEPARATOR_CHECK: r_sep_chk <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_PATTERN_LENGTH:  prdata = {26'd0, r_len};
            REG_SEPARATOR_BYTE:  prdata = {24'd0, r_sep};
            REG_SEPARATOR_CHECK: prdata = {31'd0, r_sep_chk};
            default:             prdata = 32'd0;
        endcase
    end

    always_comb begin
        w_load        = 1'b0;
        w_ctl.start   = 1'b0;
        w_ctl.advance = 1'b0;
        unique case (t_func'(i_func))
            FUNC_LOAD:  w_load        = w_accept;
            FUNC_START: w_ctl.start   = w_accept;
            FUNC_BYTE:  w_ctl.advance = w_accept;
            default: ;
        endcase
        w_ctl.blocked   = r_sep_chk && (i_text_byte == r_sep);
        w_ctl.text_byte = i_text_byte;
    end

    assign w_chain[0] = w_ctl.start;
    assign w_bit[0]   = r_row0;

    always_comb begin
        n_row0 = r_row0;
        if (w_ctl.start) begin
            n_row0 = 1'b1;
        end else if (w_ctl.advance) begin
            n_row0 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0 <= 1'b1;
        end else begin
            r_row0 <= n_row0;
        end
    end

    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        t_cell_load w_cell_load;

        assign w_cell_load.we       = w_load && (32'(i_entry_slot) == 32'(j));
        assign w_cell_load.kind     = t_kind'(i_entry_kind);
        assign w_cell_load.lit_byte = i_entry_byte;

        gpm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_load  (w_cell_load),
            .i_diag  (w_bit[j]),
            .i_chain (w_chain[j]),
            .o_bit   (w_bit[j+1]),
            .o_chain (w_chain[j+1])
        );
    end

    assign w_used = (32'(r_len) > 32'(PATTERN_MAX)) ? IDX_W'(PATTERN_MAX) : IDX_W'(r_len);

    assign w_res.valid   = w_ctl.start || w_ctl.advance;
    assign w_res.matched = w_chain[w_used];

    gpm_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res     (w_res),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_matched (o_matched),
        .o_full    (w_full)
    );

endmodule

>>> design/glob_path_match_checker.sv
`include "glob_path_match_defines.svh"

module glob_path_match_checker
    import gpm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_func,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_matched
);

    logic w_held;
    logic w_start;

    assign w_held  = o_valid && i_stall;
    assign w_start = i_valid && !o_stall && (i_func == FUNC_START);

    `GPM_ASSERT(a_held_result, w_held |=> o_valid && $stable(o_matched), "stalled result changed")
    `GPM_ASSERT(a_stall_cause, $rose(o_stall) |-> $past(w_held), "stall without a waiting result")
    `GPM_ASSERT(a_start_result, w_start && !w_held |=> o_valid, "start transfer gave no result")
    `GPM_ASSERT(a_skid_quiet, !o_stall && !w_held |=> !o_stall, "stall without a held result")
    `GPM_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_valid && !o_stall, "outputs kept over reset")

endmodule

bind glob_path_match glob_path_match_checker u_checker (.*);
